// ===== hw/rtl/ir_pulse_distance_decoder_macros.svh =====
// Assertion helpers for the pulse-distance decoder checkers.
// Each macro expects clk and rst_n in scope.
`ifndef IR_PULSE_DISTANCE_DECODER_MACROS_SVH
`define IR_PULSE_DISTANCE_DECODER_MACROS_SVH

// Same-cycle implication.
`define IPD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define IPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ipd_pkg.sv =====
package ipd_pkg;

    localparam logic [1:0] CMD_EDGE  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic [1:0] REG_CLK_PER_US  = 2'd0;
    localparam logic [1:0] REG_BIT0_MAX_US = 2'd1;
    localparam logic [1:0] REG_BIT1_MAX_US = 2'd2;
    localparam logic [1:0] REG_SILENCE_MS  = 2'd3;

    localparam logic [7:0]  RST_CLK_PER_US  = 8'd72;
    localparam logic [15:0] RST_BIT0_MAX_US = 16'd1000;
    localparam logic [15:0] RST_BIT1_MAX_US = 16'd2000;
    localparam logic [9:0]  RST_SILENCE_MS  = 10'd50;

    localparam logic [15:0] GAP_SAT   = 16'hFFFF;
    localparam logic [9:0]  QUIET_MAX = 10'd1023;

    typedef enum logic [2:0] {
        OP_QUIET,
        OP_SPACE,
        OP_TICK,
        OP_CLEAR,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] gap;
        logic [6:0]  idx;
    } qent_t;

    typedef struct packed {
        logic [7:0]  clk_per_us;
        logic [15:0] bit0_max_us;
        logic [15:0] bit1_max_us;
        logic [9:0]  silence_ms;
    } cfg_t;

    typedef struct packed {
        logic        frame_done;
        logic        frame_full;
        logic        gap_full;
        logic [2:0]  partial_bits;
        logic [7:0]  read_byte;
        logic [15:0] read_gap_us;
    } res_flags_t;

endpackage

// ===== hw/rtl/ipd_queue.sv =====
module ipd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ipd_pkg::qent_t din,
    output logic          full,
    input  logic          pop,
    output ipd_pkg::qent_t dout,
    output logic          empty
);

    localparam int DEPTH = 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    ipd_pkg::qent_t mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  cnt_reg;
    logic           do_push;
    logic           do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/ipd_front.sv =====
module ipd_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  logic [1:0]     cmd,
    input  logic [31:0]    cycle_stamp,
    input  logic           pin_high,
    input  logic [6:0]     read_index,
    input  logic           q_full,
    output logic           q_push,
    output ipd_pkg::qent_t q_data
);

    logic [31:0] last_stamp_reg;
    logic [31:0] last_stamp_next;
    logic        awaiting_reg;
    logic        awaiting_next;

    assign q_push = push && !q_full;

    always_comb
    begin
        last_stamp_next = last_stamp_reg;
        awaiting_next   = awaiting_reg;
        q_data.op       = ipd_pkg::OP_QUIET;
        q_data.gap      = cycle_stamp - last_stamp_reg;
        q_data.idx      = read_index;
        unique case (cmd)
            ipd_pkg::CMD_EDGE:
            begin
                last_stamp_next = cycle_stamp;
                awaiting_next   = 1'b0;
                if (!awaiting_reg && !pin_high)
                begin
                    q_data.op = ipd_pkg::OP_SPACE;
                end
            end
            ipd_pkg::CMD_TICK:
            begin
                q_data.op = ipd_pkg::OP_TICK;
            end
            ipd_pkg::CMD_CLEAR:
            begin
                q_data.op     = ipd_pkg::OP_CLEAR;
                awaiting_next = 1'b1;
            end
            ipd_pkg::CMD_READ:
            begin
                q_data.op = ipd_pkg::OP_READ;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_stamp_reg <= '0;
            awaiting_reg   <= 1'b1;
        end
        else if (q_push)
        begin
            last_stamp_reg <= last_stamp_next;
            awaiting_reg   <= awaiting_next;
        end
    end

endmodule

// ===== hw/rtl/ipd_div.sv =====
module ipd_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [7:0]  divisor,
    output logic        done,
    output logic [31:0] quot
);

    localparam int STEPS = 32;
    localparam int CW    = $clog2(STEPS);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [7:0]    rem_reg;
    logic [7:0]    dsr_reg;
    logic [31:0]   work_reg;
    logic [8:0]    trial;
    logic          ge;

    assign trial = {rem_reg, work_reg[31]};
    assign ge    = (trial >= {1'b0, dsr_reg});
    assign done  = done_reg;
    assign quot  = work_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= dividend;
            rem_reg  <= '0;
            dsr_reg  <= (divisor == 8'd0) ? 8'd1 : divisor;
        end
        else if (busy_reg)
        begin
            work_reg <= {work_reg[30:0], ge};
            rem_reg  <= ge ? 8'(trial - {1'b0, dsr_reg}) : trial[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(STEPS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/ipd_back.sv =====
module ipd_back #(
    parameter int FRAME_DEPTH = 32,
    parameter int GAP_DEPTH   = 128,
    localparam int FCW = $clog2(FRAME_DEPTH + 1),
    localparam int GCW = $clog2(GAP_DEPTH + 1),
    localparam int FA  = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1,
    localparam int GA  = (GAP_DEPTH > 1) ? $clog2(GAP_DEPTH) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ipd_pkg::cfg_t       cfg,
    input  logic                q_empty,
    input  ipd_pkg::qent_t      q_data,
    output logic                q_pop,
    output logic                res_valid,
    input  logic                res_pop,
    output ipd_pkg::res_flags_t res_flags,
    output logic [FCW-1:0]      res_frame_bytes,
    output logic [GCW-1:0]      res_gap_count
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_LOG  = 4'b0100,
        ST_READ = 4'b1000
    } st_t;

    st_t state_reg, state_next;

    logic [7:0]     shift_reg, shift_next;
    logic [2:0]     bits_reg, bits_next;
    logic [FCW-1:0] ffill_reg, ffill_next;
    logic           fover_reg, fover_next;
    logic [GCW-1:0] gfill_reg, gfill_next;
    logic           gover_reg, gover_next;
    logic           ready_reg, ready_next;
    logic [9:0]     quiet_reg, quiet_next;
    logic [6:0]     idx_reg, idx_next;
    logic           res_valid_reg, res_valid_next;

    ipd_pkg::res_flags_t res_flags_reg;
    logic [FCW-1:0]      res_fb_reg;
    logic [GCW-1:0]      res_gc_reg;

    logic [7:0]  frame_mem [FRAME_DEPTH];
    logic [15:0] gap_mem [GAP_DEPTH];
    logic [7:0]  fr_rdata_reg;
    logic [15:0] gp_rdata_reg;

    logic        out_free;
    logic        finish;
    logic        rd_en;
    logic        fw_en;
    logic        gw_en;
    logic        div_start;
    logic        div_done;
    logic [31:0] us;
    logic        lt0;
    logic        lt1;
    logic [15:0] gsat;
    logic [7:0]  sb;
    logic [7:0]  rbyte;
    logic [15:0] rgap;

    ipd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (q_data.gap),
        .divisor  (cfg.clk_per_us),
        .done     (div_done),
        .quot     (us)
    );

    assign out_free = !res_valid_reg || res_pop;
    assign lt0  = (us[31:16] == 16'd0) && (us[15:0] < cfg.bit0_max_us);
    assign lt1  = (us[31:16] == 16'd0) && (us[15:0] < cfg.bit1_max_us);
    assign gsat = (us[31:16] != 16'd0) ? ipd_pkg::GAP_SAT : us[15:0];
    assign sb   = {shift_reg[6:0], !lt0};

    always_comb
    begin
        state_next = state_reg;
        shift_next = shift_reg;
        bits_next  = bits_reg;
        ffill_next = ffill_reg;
        fover_next = fover_reg;
        gfill_next = gfill_reg;
        gover_next = gover_reg;
        ready_next = ready_reg;
        quiet_next = quiet_reg;
        idx_next   = idx_reg;
        finish     = 1'b0;
        rd_en      = 1'b0;
        fw_en      = 1'b0;
        gw_en      = 1'b0;
        q_pop      = 1'b0;
        div_start  = 1'b0;
        rbyte      = '0;
        rgap       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    unique case (q_data.op)
                        ipd_pkg::OP_QUIET:
                        begin
                            if (out_free)
                            begin
                                q_pop      = 1'b1;
                                quiet_next = '0;
                                finish     = 1'b1;
                            end
                        end
                        ipd_pkg::OP_TICK:
                        begin
                            if (out_free)
                            begin
                                q_pop  = 1'b1;
                                finish = 1'b1;
                                if (quiet_reg < ipd_pkg::QUIET_MAX)
                                begin
                                    quiet_next = quiet_reg + 10'd1;
                                end
                                if (!ready_reg && (gfill_reg != '0)
                                    && (quiet_next >= cfg.silence_ms))
                                begin
                                    ready_next = 1'b1;
                                end
                            end
                        end
                        ipd_pkg::OP_CLEAR:
                        begin
                            if (out_free)
                            begin
                                q_pop      = 1'b1;
                                finish     = 1'b1;
                                ffill_next = '0;
                                fover_next = 1'b0;
                                shift_next = '0;
                                bits_next  = '0;
                                gfill_next = '0;
                                gover_next = 1'b0;
                                ready_next = 1'b0;
                            end
                        end
                        ipd_pkg::OP_SPACE:
                        begin
                            q_pop      = 1'b1;
                            quiet_next = '0;
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                        ipd_pkg::OP_READ:
                        begin
                            q_pop      = 1'b1;
                            rd_en      = 1'b1;
                            idx_next   = q_data.idx;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            q_pop = 1'b0;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_LOG;
                end
            end
            ST_LOG:
            begin
                if (out_free)
                begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                    if (gfill_reg < GCW'(GAP_DEPTH))
                    begin
                        gw_en      = 1'b1;
                        gfill_next = gfill_reg + GCW'(1);
                    end
                    else
                    begin
                        gover_next = 1'b1;
                    end
                    if (lt0 || lt1)
                    begin
                        if (bits_reg == 3'd7)
                        begin
                            if (ffill_reg < FCW'(FRAME_DEPTH))
                            begin
                                fw_en      = 1'b1;
                                ffill_next = ffill_reg + FCW'(1);
                            end
                            else
                            begin
                                fover_next = 1'b1;
                            end
                            shift_next = '0;
                            bits_next  = '0;
                        end
                        else
                        begin
                            shift_next = sb;
                            bits_next  = bits_reg + 3'd1;
                        end
                    end
                    else
                    begin
                        shift_next = '0;
                        bits_next  = '0;
                    end
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                    if (16'(idx_reg) < 16'(ffill_reg))
                    begin
                        rbyte = fr_rdata_reg;
                    end
                    if (16'(idx_reg) < 16'(gfill_reg))
                    begin
                        rgap = gp_rdata_reg;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        res_valid_next = finish || (res_valid_reg && !res_pop);
    end

    always_ff @(posedge clk)
    begin
        if (fw_en)
        begin
            frame_mem[ffill_reg[FA-1:0]] <= sb;
        end
        if (rd_en)
        begin
            fr_rdata_reg <= frame_mem[FA'(q_data.idx)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (gw_en)
        begin
            gap_mem[gfill_reg[GA-1:0]] <= gsat;
        end
        if (rd_en)
        begin
            gp_rdata_reg <= gap_mem[GA'(q_data.idx)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            res_flags_reg.frame_done   <= ready_next;
            res_flags_reg.frame_full   <= fover_next;
            res_flags_reg.gap_full     <= gover_next;
            res_flags_reg.partial_bits <= bits_next;
            res_flags_reg.read_byte    <= rbyte;
            res_flags_reg.read_gap_us  <= rgap;
            res_fb_reg                 <= ffill_next;
            res_gc_reg                 <= gfill_next;
        end
        idx_reg <= idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            shift_reg     <= '0;
            bits_reg      <= '0;
            ffill_reg     <= '0;
            fover_reg     <= 1'b0;
            gfill_reg     <= '0;
            gover_reg     <= 1'b0;
            ready_reg     <= 1'b0;
            quiet_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            shift_reg     <= shift_next;
            bits_reg      <= bits_next;
            ffill_reg     <= ffill_next;
            fover_reg     <= fover_next;
            gfill_reg     <= gfill_next;
            gover_reg     <= gover_next;
            ready_reg     <= ready_next;
            quiet_reg     <= quiet_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid       = res_valid_reg;
    assign res_flags       = res_flags_reg;
    assign res_frame_bytes = res_fb_reg;
    assign res_gap_count   = res_gc_reg;

endmodule

// ===== hw/rtl/ir_pulse_distance_decoder.sv =====
// Channel   Handshake            Beat
// input     push / full          cmd, cycle_stamp, pin_high, read_index
// result    empty / pop          frame_done .. read_gap_us, one per input beat
// config    cfg_we (no stall)    cfg_addr, cfg_wdata
//
// An edge that ends a space pops the queue and starts the 32-step serial divider,
// then logs the gap once the quotient is done. Ticks, clears and other edges
// finish straight from idle in the back end; reads go through a registered store read.
// A two-beat command queue lets input beats land while the back end works or
// while a result waits on pop. Reset is asynchronous, active low; no store sweep.
module ir_pulse_distance_decoder #(
    parameter int FRAME_DEPTH = 32,
    parameter int GAP_DEPTH   = 128,
    localparam int FCW = $clog2(FRAME_DEPTH + 1),
    localparam int GCW = $clog2(GAP_DEPTH + 1)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  logic [1:0]     cmd,
    input  logic [31:0]    cycle_stamp,
    input  logic           pin_high,
    input  logic [6:0]     read_index,
    output logic           empty,
    input  logic           pop,
    output logic           frame_done,
    output logic [FCW-1:0] frame_bytes,
    output logic           frame_full,
    output logic [GCW-1:0] gap_count,
    output logic           gap_full,
    output logic [2:0]     partial_bits,
    output logic [7:0]     read_byte,
    output logic [15:0]    read_gap_us,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_addr,
    input  logic [15:0]    cfg_wdata
);

    ipd_pkg::cfg_t       cfg_reg;
    ipd_pkg::qent_t      fq_data;
    ipd_pkg::qent_t      qb_data;
    ipd_pkg::res_flags_t res_flags;
    logic                fq_push;
    logic                q_full;
    logic                q_empty;
    logic                q_pop;
    logic                res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clk_per_us  <= ipd_pkg::RST_CLK_PER_US;
            cfg_reg.bit0_max_us <= ipd_pkg::RST_BIT0_MAX_US;
            cfg_reg.bit1_max_us <= ipd_pkg::RST_BIT1_MAX_US;
            cfg_reg.silence_ms  <= ipd_pkg::RST_SILENCE_MS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                ipd_pkg::REG_CLK_PER_US:  cfg_reg.clk_per_us  <= cfg_wdata[7:0];
                ipd_pkg::REG_BIT0_MAX_US: cfg_reg.bit0_max_us <= cfg_wdata;
                ipd_pkg::REG_BIT1_MAX_US: cfg_reg.bit1_max_us <= cfg_wdata;
                ipd_pkg::REG_SILENCE_MS:  cfg_reg.silence_ms  <= cfg_wdata[9:0];
            endcase
        end
    end

    ipd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .cmd         (cmd),
        .cycle_stamp (cycle_stamp),
        .pin_high    (pin_high),
        .read_index  (read_index),
        .q_full      (q_full),
        .q_push      (fq_push),
        .q_data      (fq_data)
    );

    ipd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fq_push),
        .din   (fq_data),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (qb_data),
        .empty (q_empty)
    );

    ipd_back #(
        .FRAME_DEPTH (FRAME_DEPTH),
        .GAP_DEPTH   (GAP_DEPTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .q_empty         (q_empty),
        .q_data          (qb_data),
        .q_pop           (q_pop),
        .res_valid       (res_valid),
        .res_pop         (pop),
        .res_flags       (res_flags),
        .res_frame_bytes (frame_bytes),
        .res_gap_count   (gap_count)
    );

    assign full         = q_full;
    assign empty        = !res_valid;
    assign frame_done   = res_flags.frame_done;
    assign frame_full   = res_flags.frame_full;
    assign gap_full     = res_flags.gap_full;
    assign partial_bits = res_flags.partial_bits;
    assign read_byte    = res_flags.read_byte;
    assign read_gap_us  = res_flags.read_gap_us;

endmodule

// ===== hw/rtl/ipd_checker.sv =====
`include "ir_pulse_distance_decoder_macros.svh"

module ipd_checker #(
    parameter int FRAME_DEPTH = 32,
    parameter int GAP_DEPTH   = 128,
    localparam int FCW = $clog2(FRAME_DEPTH + 1),
    localparam int GCW = $clog2(GAP_DEPTH + 1)
) (
    input logic           clk,
    input logic           rst_n,
    input logic           empty,
    input logic           pop,
    input logic           frame_done,
    input logic [FCW-1:0] frame_bytes,
    input logic           frame_full,
    input logic [GCW-1:0] gap_count,
    input logic           gap_full
);

    `IPD_ASSERT_NOW(a_frame_bound, !empty, frame_bytes <= FCW'(FRAME_DEPTH), "frame count over depth")
    `IPD_ASSERT_NOW(a_frame_full, !empty && frame_full, frame_bytes == FCW'(FRAME_DEPTH), "frame full below depth")
    `IPD_ASSERT_NOW(a_gap_full, !empty && gap_full, gap_count == GCW'(GAP_DEPTH), "gap full below depth")
    `IPD_ASSERT_NOW(a_ready_gaps, !empty && frame_done, gap_count != '0, "ready with empty gap log")
    `IPD_ASSERT_NEXT(a_res_hold, !empty && !pop, !empty, "result dropped without pop")

endmodule

bind ir_pulse_distance_decoder ipd_checker #(
    .FRAME_DEPTH (FRAME_DEPTH),
    .GAP_DEPTH   (GAP_DEPTH)
) u_ipd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .frame_done  (frame_done),
    .frame_bytes (frame_bytes),
    .frame_full  (frame_full),
    .gap_count   (gap_count),
    .gap_full    (gap_full)
);
